// ===== rtl/bclc_pkg.sv =====
// Shared types, codes and constants for the button chord level control block.
package bclc_pkg;

  // Field and register widths
  localparam int unsigned VOLUME_W     = 6;
  localparam int unsigned BRIGHTNESS_W = 5;
  localparam int unsigned HOLD_W       = 8;
  localparam int unsigned HELD_W       = 4;
  localparam int unsigned PERCENT_W    = 9;
  localparam int unsigned BACKLIGHT_W  = 8;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 8;

  // Button codes
  localparam logic [2:0] KEY_SELECT = 3'd0;
  localparam logic [2:0] KEY_START  = 3'd1;
  localparam logic [2:0] KEY_L      = 3'd2;
  localparam logic [2:0] KEY_R      = 3'd3;

  // Key transition codes
  localparam logic [1:0] VALUE_RELEASE = 2'd0;
  localparam logic [1:0] VALUE_PRESS   = 2'd1;
  localparam logic [1:0] VALUE_REPEAT  = 2'd2;
  localparam logic [1:0] VALUE_OTHER   = 2'd3;

  // Change report codes
  localparam logic [1:0] CHANGE_NONE       = 2'd0;
  localparam logic [1:0] CHANGE_VOLUME     = 2'd1;
  localparam logic [1:0] CHANGE_BRIGHTNESS = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_MAX     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_MAX = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUSPEND_HOLD   = 2'd2;

  // Reset values
  localparam logic [VOLUME_W-1:0]     VOLUME_MAX_RESET     = 6'd20;
  localparam logic [BRIGHTNESS_W-1:0] BRIGHTNESS_MAX_RESET = 5'd10;
  localparam logic [HOLD_W-1:0]       SUSPEND_HOLD_RESET   = 8'd40;
  localparam logic [VOLUME_W-1:0]     VOLUME_RESET         = 6'd20;
  localparam logic [BRIGHTNESS_W-1:0] BRIGHTNESS_RESET     = 5'd10;

  // Limits and output scaling
  localparam logic [HELD_W-1:0]      HELD_LIMIT     = 4'd15;
  localparam logic [HOLD_W-1:0]      HOLD_LIMIT     = 8'd255;
  localparam logic [BACKLIGHT_W-1:0] BACKLIGHT_BASE = 8'd70;

  typedef struct packed {
    logic       is_key;
    logic [2:0] key_code;
    logic [1:0] key_value;
  } key_event_t;

  typedef struct packed {
    logic [VOLUME_W-1:0]     volume_level;
    logic [PERCENT_W-1:0]    volume_percent;
    logic [BRIGHTNESS_W-1:0] brightness_level;
    logic [BACKLIGHT_W-1:0]  backlight_raw;
    logic [1:0]              level_changed;
    logic                    suspend_request;
  } level_result_t;

endpackage

// ===== rtl/button_chord_level_control_top.sv =====
// Button chord level control: key event register, state update and result register.
// Events pass through the key event register, then into the result register.
// Throughput: one event per cycle while result_stall is low; the two registers
// together let a new event be taken while a finished result still waits downstream.
// Reset (rst, synchronous): levels return to 20 and 10, limits to 20, 10 and 40,
// held state and repeat phase clear, both registers empty.
module button_chord_level_control_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [bclc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [bclc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  key_valid,
  output logic                                  key_stall,
  input  bclc_pkg::key_event_t                  key_event,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output bclc_pkg::level_result_t               result
);

  // Configuration registers
  logic [bclc_pkg::VOLUME_W-1:0]     volume_max;
  logic [bclc_pkg::BRIGHTNESS_W-1:0] brightness_max;
  logic [bclc_pkg::HOLD_W-1:0]       suspend_hold;

  // Chord state
  logic [bclc_pkg::HELD_W-1:0]       held_count, held_count_next;
  logic                              select_held, select_held_next;
  logic                              start_held, start_held_next;
  logic [bclc_pkg::HOLD_W-1:0]       start_hold_count, start_hold_count_next;
  logic                              repeat_phase, repeat_phase_next;
  logic [bclc_pkg::VOLUME_W-1:0]     volume_now, volume_now_next;
  logic [bclc_pkg::BRIGHTNESS_W-1:0] brightness_now, brightness_now_next;

  // Pipeline registers
  logic                    key_q_valid;
  bclc_pkg::key_event_t    key_q;
  bclc_pkg::level_result_t result_next;

  logic out_ready;
  logic advance;
  logic live;
  logic act;
  logic [1:0] changed;
  logic suspend;
  logic [bclc_pkg::HELD_W-1:0] held_after;

  assign out_ready = !result_valid || !result_stall;
  assign advance   = key_q_valid && out_ready;
  assign key_stall = key_q_valid && !out_ready;

  // Write configuration registers; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_max     <= bclc_pkg::VOLUME_MAX_RESET;
      brightness_max <= bclc_pkg::BRIGHTNESS_MAX_RESET;
      suspend_hold   <= bclc_pkg::SUSPEND_HOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bclc_pkg::REG_VOLUME_MAX:     volume_max     <= cfg_data[bclc_pkg::VOLUME_W-1:0];
        bclc_pkg::REG_BRIGHTNESS_MAX: brightness_max <= cfg_data[bclc_pkg::BRIGHTNESS_W-1:0];
        bclc_pkg::REG_SUSPEND_HOLD:   suspend_hold   <= cfg_data[bclc_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold an accepted transaction until the result register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      key_q_valid <= 1'b0;
    end else if (!key_stall) begin
      key_q_valid <= key_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!key_stall && key_valid) begin
      key_q <= key_event;
    end
  end

  // Work out the next chord state and levels for the held transaction
  always_comb begin
    held_count_next       = held_count;
    select_held_next      = select_held;
    start_held_next       = start_held;
    start_hold_count_next = start_hold_count;
    repeat_phase_next     = repeat_phase;
    volume_now_next       = volume_now;
    brightness_now_next   = brightness_now;
    changed               = bclc_pkg::CHANGE_NONE;
    suspend               = 1'b0;
    act                   = 1'b0;
    held_after            = held_count;

    live = key_q.is_key && (key_q.key_value != bclc_pkg::VALUE_OTHER);

    // Count held buttons, saturating at both ends
    if (key_q.key_value == bclc_pkg::VALUE_PRESS) begin
      if (held_count != bclc_pkg::HELD_LIMIT) begin
        held_after = held_count + 4'd1;
      end
    end else if (key_q.key_value == bclc_pkg::VALUE_RELEASE) begin
      if (held_count != '0) begin
        held_after = held_count - 4'd1;
      end
    end

    if (live) begin
      held_count_next = held_after;
      case (key_q.key_code)
        bclc_pkg::KEY_SELECT: begin
          if (key_q.key_value != bclc_pkg::VALUE_REPEAT) begin
            select_held_next = key_q.key_value[0];
          end
        end
        bclc_pkg::KEY_START: begin
          if (key_q.key_value != bclc_pkg::VALUE_REPEAT) begin
            start_held_next = key_q.key_value[0];
            start_hold_count_next = (held_after == 4'd1) ?
                                    {{(bclc_pkg::HOLD_W-1){1'b0}}, key_q.key_value[0]} : '0;
          end else if (start_hold_count != '0) begin
            if (start_hold_count != bclc_pkg::HOLD_LIMIT) begin
              start_hold_count_next = start_hold_count + 8'd1;
            end
            // Long START-only hold: request suspend and drop the held state
            if (start_hold_count > suspend_hold) begin
              suspend               = 1'b1;
              select_held_next      = 1'b0;
              start_held_next       = 1'b0;
              start_hold_count_next = '0;
              held_count_next       = '0;
            end
          end
        end
        bclc_pkg::KEY_L, bclc_pkg::KEY_R: begin
          // Repeats act on every other event
          if (key_q.key_value == bclc_pkg::VALUE_REPEAT) begin
            act               = repeat_phase;
            repeat_phase_next = !repeat_phase;
          end else begin
            act               = key_q.key_value[0];
            repeat_phase_next = 1'b0;
          end
          if (act) begin
            if (select_held && !start_held) begin
              if (key_q.key_code == bclc_pkg::KEY_R) begin
                if (volume_now < volume_max) begin
                  volume_now_next = volume_now + 6'd1;
                  changed         = bclc_pkg::CHANGE_VOLUME;
                end
              end else if (volume_now != '0) begin
                volume_now_next = volume_now - 6'd1;
                changed         = bclc_pkg::CHANGE_VOLUME;
              end
            end else if (start_held && !select_held) begin
              if (key_q.key_code == bclc_pkg::KEY_R) begin
                if (brightness_now < brightness_max) begin
                  brightness_now_next = brightness_now + 5'd1;
                  changed             = bclc_pkg::CHANGE_BRIGHTNESS;
                end
              end else if (brightness_now != '0) begin
                brightness_now_next = brightness_now - 5'd1;
                changed             = bclc_pkg::CHANGE_BRIGHTNESS;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // Build the result from the updated levels
    result_next.volume_level     = volume_now_next;
    result_next.volume_percent   = {1'b0, volume_now_next, 2'b00}
                                 + {3'b000, volume_now_next};
    result_next.brightness_level = brightness_now_next;
    result_next.backlight_raw    = bclc_pkg::BACKLIGHT_BASE
                                 + {1'b0, brightness_now_next, 2'b00}
                                 + {3'b000, brightness_now_next};
    result_next.level_changed    = changed;
    result_next.suspend_request  = suspend;
  end

  // Advance the chord state once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count       <= '0;
      select_held      <= 1'b0;
      start_held       <= 1'b0;
      start_hold_count <= '0;
      repeat_phase     <= 1'b0;
      volume_now       <= bclc_pkg::VOLUME_RESET;
      brightness_now   <= bclc_pkg::BRIGHTNESS_RESET;
    end else if (advance) begin
      held_count       <= held_count_next;
      select_held      <= select_held_next;
      start_held       <= start_held_next;
      start_hold_count <= start_hold_count_next;
      repeat_phase     <= repeat_phase_next;
      volume_now       <= volume_now_next;
      brightness_now   <= brightness_now_next;
    end
  end

  // Load the result register when it is free or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= key_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // A suspend result never reports a level step
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.suspend_request) |-> (result.level_changed == bclc_pkg::CHANGE_NONE))
    else $error("suspend result reports a level change");

  // A suspend clears every held flag and counter
  assert property (@(posedge clk) disable iff (rst)
    (advance && result_next.suspend_request) |=>
      (held_count == '0 && !select_held && !start_held && start_hold_count == '0))
    else $error("held state not cleared after suspend");

  // Levels only move when a transaction advances
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(volume_now) && $stable(brightness_now)))
    else $error("level changed without a transaction");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the button chord level control block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Button codes with no function of their own
  localparam logic [2:0] KEY_MISC   = 3'd4;
  localparam logic [2:0] KEY_SPARE5 = 3'd5;
  localparam logic [2:0] KEY_SPARE6 = 3'd6;
  localparam logic [2:0] KEY_SPARE7 = 3'd7;

  // Register index past the end of the map
  localparam logic [bclc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [bclc_pkg::PERCENT_W-1:0] LEVEL_SCALE    = 9'd5;
  localparam int unsigned                    SETTLE_CYCLES  = 6;
  localparam int unsigned                    WATCHDOG_LIMIT = 3000;
  localparam int unsigned                    LOG_CAP        = 50;

  logic                                  clk;
  logic                                  rst          = 1'b1;
  logic                                  cfg_write    = 1'b0;
  logic [bclc_pkg::CFG_INDEX_W-1:0]      cfg_index    = '0;
  logic [bclc_pkg::CFG_DATA_W-1:0]       cfg_data     = '0;
  logic                                  key_valid    = 1'b0;
  logic                                  key_stall;
  bclc_pkg::key_event_t                  key_event    = '0;
  logic                                  result_valid;
  logic                                  result_stall = 1'b0;
  bclc_pkg::level_result_t               result;

  // Predicted limits and chord state
  logic [bclc_pkg::VOLUME_W-1:0]     vol_max     = bclc_pkg::VOLUME_MAX_RESET;
  logic [bclc_pkg::BRIGHTNESS_W-1:0] bri_max     = bclc_pkg::BRIGHTNESS_MAX_RESET;
  logic [bclc_pkg::HOLD_W-1:0]       susp_limit  = bclc_pkg::SUSPEND_HOLD_RESET;
  logic [bclc_pkg::HELD_W-1:0]       held_cnt    = '0;
  logic                              sel_down    = 1'b0;
  logic                              start_down  = 1'b0;
  logic [bclc_pkg::HOLD_W-1:0]       hold_cnt    = '0;
  logic                              rep_phase   = 1'b0;
  logic [bclc_pkg::VOLUME_W-1:0]     vol_now     = bclc_pkg::VOLUME_RESET;
  logic [bclc_pkg::BRIGHTNESS_W-1:0] bri_now     = bclc_pkg::BRIGHTNESS_RESET;

  bclc_pkg::level_result_t level_q [$];
  bclc_pkg::level_result_t oldest;
  int unsigned             mismatches   = 0;
  int unsigned             events_taken = 0;
  int unsigned             quiet_cycles = 0;
  bit                      calm         = 1'b0;

  typedef struct {
    bclc_pkg::key_event_t    ev;
    bit                      typed;
    bclc_pkg::level_result_t want;
  } dir_row_t;

  // Opening stimulus; typed rows carry their expected levels, the rest use the predictor
  dir_row_t directed_rows [25] = '{
    '{'{1'b0, bclc_pkg::KEY_SELECT, bclc_pkg::VALUE_PRESS}, 1'b1,
      '{6'd20, 9'd100, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_START, bclc_pkg::VALUE_OTHER}, 1'b1,
      '{6'd20, 9'd100, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, KEY_MISC, bclc_pkg::VALUE_RELEASE}, 1'b1,
      '{6'd20, 9'd100, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_SELECT, bclc_pkg::VALUE_PRESS}, 1'b1,
      '{6'd20, 9'd100, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_R, bclc_pkg::VALUE_PRESS}, 1'b1,
      '{6'd20, 9'd100, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_R, bclc_pkg::VALUE_RELEASE}, 1'b1,
      '{6'd20, 9'd100, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_L, bclc_pkg::VALUE_PRESS}, 1'b1,
      '{6'd19, 9'd95, 5'd10, 8'd120, bclc_pkg::CHANGE_VOLUME, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_L, bclc_pkg::VALUE_REPEAT}, 1'b1,
      '{6'd19, 9'd95, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_L, bclc_pkg::VALUE_REPEAT}, 1'b1,
      '{6'd18, 9'd90, 5'd10, 8'd120, bclc_pkg::CHANGE_VOLUME, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_L, bclc_pkg::VALUE_RELEASE}, 1'b1,
      '{6'd18, 9'd90, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_SELECT, bclc_pkg::VALUE_RELEASE}, 1'b1,
      '{6'd18, 9'd90, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_START, bclc_pkg::VALUE_PRESS},    1'b0, '0},
    '{'{1'b1, bclc_pkg::KEY_START, bclc_pkg::VALUE_REPEAT},   1'b0, '0},
    '{'{1'b1, bclc_pkg::KEY_R, bclc_pkg::VALUE_PRESS}, 1'b1,
      '{6'd18, 9'd90, 5'd10, 8'd120, bclc_pkg::CHANGE_NONE, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_L, bclc_pkg::VALUE_PRESS}, 1'b1,
      '{6'd18, 9'd90, 5'd9, 8'd115, bclc_pkg::CHANGE_BRIGHTNESS, 1'b0}},
    '{'{1'b1, bclc_pkg::KEY_SELECT, bclc_pkg::VALUE_PRESS},   1'b0, '0},
    '{'{1'b1, bclc_pkg::KEY_L, bclc_pkg::VALUE_PRESS},        1'b0, '0},
    '{'{1'b1, KEY_SPARE7, bclc_pkg::VALUE_PRESS},             1'b0, '0},
    '{'{1'b1, KEY_SPARE5, bclc_pkg::VALUE_REPEAT},            1'b0, '0},
    '{'{1'b1, KEY_SPARE6, bclc_pkg::VALUE_RELEASE},           1'b0, '0},
    '{'{1'b1, bclc_pkg::KEY_SELECT, bclc_pkg::VALUE_REPEAT},  1'b0, '0},
    '{'{1'b1, bclc_pkg::KEY_SELECT, bclc_pkg::VALUE_RELEASE}, 1'b0, '0},
    '{'{1'b1, bclc_pkg::KEY_START, bclc_pkg::VALUE_RELEASE},  1'b0, '0},
    '{'{1'b0, KEY_SPARE7, bclc_pkg::VALUE_OTHER},             1'b0, '0},
    '{'{1'b1, KEY_MISC, bclc_pkg::VALUE_PRESS},               1'b0, '0}
  };

  button_chord_level_control_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .key_valid    (key_valid),
    .key_stall    (key_stall),
    .key_event    (key_event),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the chord state by one key event and give the levels it leaves
  function automatic bclc_pkg::level_result_t step_levels(input bclc_pkg::key_event_t ev);
    bclc_pkg::level_result_t     r;
    logic [1:0]                  chg;
    logic                        susp;
    logic                        act;
    logic [bclc_pkg::HOLD_W-1:0] prior;
    chg  = bclc_pkg::CHANGE_NONE;
    susp = 1'b0;
    if (ev.is_key && ev.key_value != bclc_pkg::VALUE_OTHER) begin
      if (ev.key_value == bclc_pkg::VALUE_PRESS) begin
        if (held_cnt != bclc_pkg::HELD_LIMIT) held_cnt++;
      end else if (ev.key_value == bclc_pkg::VALUE_RELEASE) begin
        if (held_cnt != '0) held_cnt--;
      end
      case (ev.key_code)
        bclc_pkg::KEY_SELECT: begin
          if (ev.key_value != bclc_pkg::VALUE_REPEAT) sel_down = ev.key_value[0];
        end
        bclc_pkg::KEY_START: begin
          if (ev.key_value != bclc_pkg::VALUE_REPEAT) begin
            start_down = ev.key_value[0];
            hold_cnt   = (held_cnt == 4'd1) ? bclc_pkg::HOLD_W'(ev.key_value[0]) : '0;
          end else if (hold_cnt != '0) begin
            prior = hold_cnt;
            if (hold_cnt != bclc_pkg::HOLD_LIMIT) hold_cnt++;
            // long START-only hold: request suspend and forget every held button
            if (prior > susp_limit) begin
              susp       = 1'b1;
              sel_down   = 1'b0;
              start_down = 1'b0;
              hold_cnt   = '0;
              held_cnt   = '0;
            end
          end
        end
        bclc_pkg::KEY_L, bclc_pkg::KEY_R: begin
          // auto-repeat acts on every second event only
          if (ev.key_value == bclc_pkg::VALUE_REPEAT) begin
            act       = rep_phase;
            rep_phase = ~rep_phase;
          end else begin
            act       = ev.key_value[0];
            rep_phase = 1'b0;
          end
          if (act && sel_down && !start_down) begin
            if (ev.key_code == bclc_pkg::KEY_R) begin
              if (vol_now < vol_max) begin
                vol_now++;
                chg = bclc_pkg::CHANGE_VOLUME;
              end
            end else if (vol_now != '0) begin
              vol_now--;
              chg = bclc_pkg::CHANGE_VOLUME;
            end
          end else if (act && start_down && !sel_down) begin
            if (ev.key_code == bclc_pkg::KEY_R) begin
              if (bri_now < bri_max) begin
                bri_now++;
                chg = bclc_pkg::CHANGE_BRIGHTNESS;
              end
            end else if (bri_now != '0) begin
              bri_now--;
              chg = bclc_pkg::CHANGE_BRIGHTNESS;
            end
          end
        end
        default: ;
      endcase
    end
    r.volume_level     = vol_now;
    r.volume_percent   = bclc_pkg::PERCENT_W'(vol_now) * LEVEL_SCALE;
    r.brightness_level = bri_now;
    r.backlight_raw    = bclc_pkg::BACKLIGHT_BASE
                       + bclc_pkg::BACKLIGHT_W'(bri_now) * bclc_pkg::BACKLIGHT_W'(LEVEL_SCALE);
    r.level_changed    = chg;
    r.suspend_request  = susp;
    return r;
  endfunction

  function automatic bclc_pkg::key_event_t make_key(input logic [2:0] code,
                                                    input logic [1:0] value);
    bclc_pkg::key_event_t ev;
    ev.is_key    = 1'b1;
    ev.key_code  = code;
    ev.key_value = value;
    return ev;
  endfunction

  task automatic report_mismatch(input string what);
    // keep the log short once things go badly wrong
    if (mismatches < LOG_CAP) $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Offer one key event, hold it until taken, then queue its expected levels
  task automatic send_key(input bclc_pkg::key_event_t ev, input bit typed = 1'b0,
                          input bclc_pkg::level_result_t want = '0);
    bclc_pkg::level_result_t predicted;
    while (!calm && $urandom_range(99) < 23) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid <= 1'b1;
    key_event <= ev;
    @(posedge clk);
    while (key_stall) @(posedge clk);
    predicted = step_levels(ev);
    level_q.push_back(typed ? want : predicted);
    if (ev.is_key && ev.key_value != bclc_pkg::VALUE_OTHER) events_taken++;
  endtask

  // Press a button, let it auto-repeat, release it
  task automatic hold_key(input logic [2:0] code, input int unsigned reps);
    send_key(make_key(code, bclc_pkg::VALUE_PRESS));
    repeat (reps) send_key(make_key(code, bclc_pkg::VALUE_REPEAT));
    send_key(make_key(code, bclc_pkg::VALUE_RELEASE));
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_levels_settled();
    key_valid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [bclc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bclc_pkg::CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      bclc_pkg::REG_VOLUME_MAX:     vol_max    = data[bclc_pkg::VOLUME_W-1:0];
      bclc_pkg::REG_BRIGHTNESS_MAX: bri_max    = data[bclc_pkg::BRIGHTNESS_W-1:0];
      bclc_pkg::REG_SUSPEND_HOLD:   susp_limit = data;
      default: ;
    endcase
  endtask

  // Load new limits with the block idle; bits above each register's width are random
  task automatic set_limits(input logic [bclc_pkg::VOLUME_W-1:0] vmax,
                            input logic [bclc_pkg::BRIGHTNESS_W-1:0] bmax,
                            input logic [bclc_pkg::HOLD_W-1:0] hold);
    wait_levels_settled();
    write_limit(bclc_pkg::REG_VOLUME_MAX, {2'($urandom), vmax});
    write_limit(bclc_pkg::REG_BRIGHTNESS_MAX, {3'($urandom), bmax});
    write_limit(bclc_pkg::REG_SUSPEND_HOLD, hold);
    if ($urandom_range(1) == 1) write_limit(REG_UNUSED, 8'($urandom));
  endtask

  // One random sequence: mostly well-formed chords and START holds, some noise
  task automatic play_sequence();
    int unsigned          pick;
    int unsigned          taps;
    int unsigned          bias;
    int unsigned          reps;
    logic [2:0]           modifier;
    logic [2:0]           second;
    bit                   both;
    bclc_pkg::key_event_t ev;
    pick = $urandom_range(99);
    if (pick < 55) begin
      modifier = ($urandom_range(1) == 1) ? bclc_pkg::KEY_SELECT : bclc_pkg::KEY_START;
      second   = (modifier == bclc_pkg::KEY_SELECT) ? bclc_pkg::KEY_START : bclc_pkg::KEY_SELECT;
      both     = ($urandom_range(7) == 0);
      bias     = $urandom_range(100);
      send_key(make_key(modifier, bclc_pkg::VALUE_PRESS));
      if (both) send_key(make_key(second, bclc_pkg::VALUE_PRESS));
      taps = $urandom_range(1, 6);
      repeat (taps) begin
        // now and then a long auto-repeat sweep towards a level limit
        reps = ($urandom_range(11) == 0) ? 2 * $urandom_range(20, 60) : $urandom_range(0, 5);
        hold_key(($urandom_range(99) < bias) ? bclc_pkg::KEY_R : bclc_pkg::KEY_L, reps);
      end
      if (both) send_key(make_key(second, bclc_pkg::VALUE_RELEASE));
      send_key(make_key(modifier, bclc_pkg::VALUE_RELEASE));
    end else if (pick < 65) begin
      reps = ($urandom_range(3) == 0) ? $urandom_range(0, 6) : susp_limit + $urandom_range(0, 3);
      hold_key(bclc_pkg::KEY_START, reps);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 4)) begin
        ev.is_key    = 1'($urandom);
        ev.key_code  = 3'($urandom);
        ev.key_value = 2'($urandom);
        send_key(ev);
      end
    end else if (pick < 95) begin
      // pile up presses up to or past the held count limit, then let them all go
      reps = $urandom_range(12, 18);
      repeat (reps) send_key(make_key(KEY_MISC, bclc_pkg::VALUE_PRESS));
      repeat (reps) send_key(make_key(KEY_MISC, bclc_pkg::VALUE_RELEASE));
    end else begin
      send_key(make_key(3'($urandom_range(0, 3)), 2'($urandom_range(0, 1))));
    end
  endtask

  task automatic play_until(input int unsigned budget);
    int unsigned first;
    first = events_taken;
    while (events_taken - first < budget) play_sequence();
  endtask

  // Result side: check each transaction, stall at random
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (level_q.size() == 0) begin
          report_mismatch("result with no expectation outstanding");
        end else begin
          oldest = level_q.pop_front();
          check_field("volume_level", 9'(result.volume_level), 9'(oldest.volume_level));
          check_field("volume_percent", result.volume_percent, oldest.volume_percent);
          check_field("brightness_level", 9'(result.brightness_level),
                      9'(oldest.brightness_level));
          check_field("backlight_raw", 9'(result.backlight_raw), 9'(oldest.backlight_raw));
          check_field("level_changed", 9'(result.level_changed), 9'(oldest.level_changed));
          check_field("suspend_request", 9'(result.suspend_request),
                      9'(oldest.suspend_request));
        end
      end
      result_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  // Watchdog: give up when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (key_valid && !key_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_key(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    end
    play_until(110);

    // largest level limits, then smallest: levels can end up above their maxima
    set_limits(6'd63, 5'd31, 8'd254);
    play_until(130);
    set_limits(6'd1, 5'd1, 8'd0);
    play_until(110);

    // a stretch with no idling on either side
    calm = 1'b1;
    set_limits(6'($urandom_range(1, 63)), 5'($urandom_range(1, 31)), 8'($urandom_range(0, 12)));
    play_until(120);
    calm = 1'b0;

    set_limits(6'($urandom_range(1, 63)), 5'($urandom_range(1, 31)), 8'($urandom_range(0, 254)));
    play_until(120);
    set_limits(6'($urandom_range(1, 63)), 5'($urandom_range(1, 31)), 8'($urandom_range(0, 20)));
    play_until(120);

    wait_levels_settled();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
